>>> rtl/keypad_event_translator_with_repeat_top_assert.svh
// Assertion macros used by the checker file of this block.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef KEYPAD_EVENT_TRANSLATOR_WITH_REPEAT_TOP_ASSERT_SVH
`define KEYPAD_EVENT_TRANSLATOR_WITH_REPEAT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KETR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KETR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ketr_pkg.sv
`default_nettype none

package ketr_pkg;

   // Key codes with a fixed role.
   localparam logic [6:0] KEY_SHIFT_L = 7'd35;
   localparam logic [6:0] KEY_SHIFT_R = 7'd31;
   localparam logic [6:0] KEY_ALT     = 7'd30;
   localparam logic [6:0] KEY_SYM     = 7'd32;
   localparam logic [6:0] KEY_DOLLAR  = 7'd22;
   localparam logic [6:0] KEY_MIC     = 7'd34;
   localparam logic [6:0] KEY_NONE    = 7'd0;

   // Characters and offsets.
   localparam logic [6:0] CHAR_NONE   = 7'd0;
   localparam logic [6:0] CHAR_DOLLAR = 7'h24;
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_MIC    = 7'h02;
   localparam logic [6:0] CHAR_LOW_A  = 7'h61;
   localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;
   localparam logic [6:0] CASE_OFFSET = 7'd32;

   // Event byte layout.
   localparam int PRESS_BIT = 7;

   // Register map.
   localparam int         CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_DELAY  = 2'd1;
   localparam logic [1:0] REG_RATE   = 2'd2;

   localparam logic [15:0] DELAY_RESET = 16'd400;
   localparam logic [15:0] RATE_RESET  = 16'd150;

   // Sticky modifier state: active, physically held, used while held.
   typedef struct packed {
      logic used;
      logic held;
      logic active;
   } mod_type;

   localparam mod_type MOD_PRESSED = '{used: 1'b0, held: 1'b1, active: 1'b1};

   typedef struct packed {
      logic        enable;
      logic [15:0] delay;
      logic [15:0] rate;
   } cfg_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       from_repeat;
      logic       shift_on;
      logic       alt_on;
      logic       sym_on;
   } result_type;

   // A key that uses a modifier drops a tapped one and marks a held one.
   function automatic mod_type consume_mod(input mod_type f);
      mod_type r;
      r = f;
      if (f.active) begin
         if (f.held) begin
            r.used = 1'b1;
         end else begin
            r.active = 1'b0;
         end
      end
      return r;
   endfunction

   // Release keeps a tapped modifier armed unless it served keys while held.
   function automatic mod_type release_mod(input mod_type f);
      mod_type r;
      r.held   = 1'b0;
      r.used   = 1'b0;
      r.active = f.active & ~f.used;
      return r;
   endfunction

   // Base key map.
   function automatic logic [6:0] base_char(input logic [6:0] code);
      logic [6:0] c;
      case (code)
         7'd10:   c = 7'h71; // q
         7'd9:    c = 7'h77; // w
         7'd8:    c = 7'h65; // e
         7'd7:    c = 7'h72; // r
         7'd6:    c = 7'h74; // t
         7'd5:    c = 7'h79; // y
         7'd4:    c = 7'h75; // u
         7'd3:    c = 7'h69; // i
         7'd2:    c = 7'h6F; // o
         7'd1:    c = 7'h70; // p
         7'd20:   c = 7'h61; // a
         7'd19:   c = 7'h73; // s
         7'd18:   c = 7'h64; // d
         7'd17:   c = 7'h66; // f
         7'd16:   c = 7'h67; // g
         7'd15:   c = 7'h68; // h
         7'd14:   c = 7'h6A; // j
         7'd13:   c = 7'h6B; // k
         7'd12:   c = 7'h6C; // l
         7'd11:   c = 7'h08; // backspace
         7'd29:   c = 7'h7A; // z
         7'd28:   c = 7'h78; // x
         7'd27:   c = 7'h63; // c
         7'd26:   c = 7'h76; // v
         7'd25:   c = 7'h62; // b
         7'd24:   c = 7'h6E; // n
         7'd23:   c = 7'h6D; // m
         7'd21:   c = 7'h0D; // enter
         7'd33:   c = 7'h20; // space
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   // Symbol key map.
   function automatic logic [6:0] sym_char(input logic [6:0] code);
      logic [6:0] c;
      case (code)
         7'd10:   c = 7'h23; // #
         7'd9:    c = 7'h31; // 1
         7'd8:    c = 7'h32; // 2
         7'd7:    c = 7'h33; // 3
         7'd6:    c = 7'h28; // (
         7'd5:    c = 7'h29; // )
         7'd4:    c = 7'h5F; // _
         7'd3:    c = 7'h2D; // -
         7'd2:    c = 7'h2B; // +
         7'd1:    c = 7'h40; // @
         7'd20:   c = 7'h2A; // *
         7'd19:   c = 7'h34; // 4
         7'd18:   c = 7'h35; // 5
         7'd17:   c = 7'h36; // 6
         7'd16:   c = 7'h2F; // /
         7'd15:   c = 7'h3A; // :
         7'd14:   c = 7'h3B; // ;
         7'd13:   c = 7'h27; // '
         7'd12:   c = 7'h22; // "
         7'd29:   c = 7'h37; // 7
         7'd28:   c = 7'h38; // 8
         7'd27:   c = 7'h39; // 9
         7'd26:   c = 7'h3F; // ?
         7'd25:   c = 7'h21; // !
         7'd24:   c = 7'h2C; // ,
         7'd23:   c = 7'h2E; // .
         7'd34:   c = 7'h30; // 0
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/keypad_event_translator_with_repeat_top.sv
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_kind, req_event_byte
// rsp      out        rsp_valid/rsp_stall rsp_char_valid, rsp_char_code, rsp_from_repeat,
//                                         rsp_shift_on, rsp_alt_on, rsp_sym_on
// csr      in/out     psel/penable/pready paddr, pwrite, pwdata, prdata
//
// One item per cycle is sustained while no result is stalled; each item gives exactly one result.
// An item passes through an input register, then the translation step into the result register.
// Reset is synchronous and active high; it clears all key state and loads register defaults.
// A stalled result holds; one more item may wait in the input register before req_stall rises.
`default_nettype none

module keypad_event_translator_with_repeat_top
   import ketr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_event_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_char_valid,
   output logic [6:0]                 rsp_char_code,
   output logic                       rsp_from_repeat,
   output logic                       rsp_shift_on,
   output logic                       rsp_alt_on,
   output logic                       rsp_sym_on,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type step_result;
   logic       advance;
   logic       step_en;
   logic       req_accept;
   logic       csr_write;
   logic [1:0] csr_index;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.delay  <= DELAY_RESET;
         cfg_ff.rate   <= RATE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENABLE: cfg_ff.enable <= pwdata[0];
            REG_DELAY:  cfg_ff.delay  <= pwdata[15:0];
            REG_RATE:   cfg_ff.rate   <= pwdata[15:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ENABLE: prdata = {31'd0, cfg_ff.enable};
         REG_DELAY:  prdata = {16'd0, cfg_ff.delay};
         REG_RATE:   prdata = {16'd0, cfg_ff.rate};
         default:    prdata = 32'd0;
      endcase
   end

   // Pipeline control: both stages move unless a result is stalled.
   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign step_en    = in_valid_ff && advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_event_byte;
      end
   end

   ketr_step #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .kind       (in_kind_ff),
      .event_byte (in_byte_ff),
      .cfg        (cfg_ff),
      .result     (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_valid  = rsp_data_ff.char_valid;
   assign rsp_char_code   = rsp_data_ff.char_code;
   assign rsp_from_repeat = rsp_data_ff.from_repeat;
   assign rsp_shift_on    = rsp_data_ff.shift_on;
   assign rsp_alt_on      = rsp_data_ff.alt_on;
   assign rsp_sym_on      = rsp_data_ff.sym_on;

endmodule

`default_nettype wire

>>> rtl/ketr_step.sv
`default_nettype none

module ketr_step
   import ketr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic       kind,
   input  wire logic [7:0] event_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

   mod_type                  shift_ff, shift_in;
   mod_type                  alt_ff, alt_in;
   mod_type                  sym_ff, sym_in;
   logic [6:0]               held_key_ff, held_key_in;
   logic [6:0]               held_char_ff, held_char_in;
   logic [COUNTER_WIDTH-1:0] since_press_ff, since_press_in;
   logic [COUNTER_WIDTH-1:0] since_repeat_ff, since_repeat_in;
   logic                     repeated_once_ff, repeated_once_in;

   logic                     pressed;
   logic [6:0]               code;
   logic                     is_shift;
   logic [6:0]               c;
   logic [6:0]               base_c;
   logic [6:0]               sym_c;
   logic                     rep;
   logic [COUNTER_WIDTH-1:0] press_inc;
   logic [COUNTER_WIDTH-1:0] repeat_inc;
   logic                     delay_met;
   logic                     rate_met;

   assign pressed  = event_byte[PRESS_BIT];
   assign code     = event_byte[6:0];
   assign is_shift = (code == KEY_SHIFT_L) || (code == KEY_SHIFT_R);
   assign base_c   = base_char(code);
   assign sym_c    = sym_char(code);

   // Saturating tick counters and the repeat thresholds.
   assign press_inc  = (&since_press_ff) ? since_press_ff : since_press_ff + 1'b1;
   assign repeat_inc = (&since_repeat_ff) ? since_repeat_ff : since_repeat_ff + 1'b1;
   assign delay_met  = CMP_W'(press_inc) >= CMP_W'(cfg.delay);
   assign rate_met   = CMP_W'(repeat_inc) >= CMP_W'(cfg.rate);

   // Next state and character for the item in the input register.
   always_comb begin
      shift_in         = shift_ff;
      alt_in           = alt_ff;
      sym_in           = sym_ff;
      held_key_in      = held_key_ff;
      held_char_in     = held_char_ff;
      since_press_in   = since_press_ff;
      since_repeat_in  = since_repeat_ff;
      repeated_once_in = repeated_once_ff;
      c                = CHAR_NONE;
      rep              = 1'b0;
      if (cfg.enable) begin
         if (!kind) begin
            if (!pressed) begin
               if (is_shift) begin
                  shift_in = release_mod(shift_ff);
               end
               if (code == KEY_ALT) begin
                  alt_in = release_mod(alt_ff);
               end
               if (code == KEY_SYM) begin
                  sym_in = release_mod(sym_ff);
               end
               if (code == held_key_ff) begin
                  held_key_in = KEY_NONE;
               end
            end else if (is_shift) begin
               shift_in = MOD_PRESSED;
            end else if (code == KEY_ALT) begin
               alt_in = MOD_PRESSED;
            end else if (code == KEY_SYM) begin
               sym_in = MOD_PRESSED;
            end else begin
               // Character keys, special keys first.
               if (code == KEY_DOLLAR) begin
                  c             = CHAR_DOLLAR;
                  sym_in.active = 1'b0;
               end else if (code == KEY_MIC) begin
                  if (alt_ff.active || sym_ff.active) begin
                     c      = CHAR_ZERO;
                     alt_in = consume_mod(alt_ff);
                     sym_in = consume_mod(sym_ff);
                  end else begin
                     c = CHAR_MIC;
                  end
               end else if (alt_ff.active || sym_ff.active) begin
                  c      = (sym_c != CHAR_NONE) ? sym_c : base_c;
                  alt_in = consume_mod(alt_ff);
                  sym_in = consume_mod(sym_ff);
               end else begin
                  c = base_c;
                  if ((base_c != CHAR_NONE) && shift_ff.active) begin
                     if ((base_c >= CHAR_LOW_A) && (base_c <= CHAR_LOW_Z)) begin
                        c = base_c - CASE_OFFSET;
                     end
                     shift_in = consume_mod(shift_ff);
                  end
               end
               // A key that yields a character becomes the held key.
               if (c != CHAR_NONE) begin
                  held_key_in      = code;
                  held_char_in     = c;
                  since_press_in   = '0;
                  since_repeat_in  = '0;
                  repeated_once_in = 1'b0;
               end
            end
         end else begin
            // Millisecond tick: advance counters and fire a repeat when due.
            since_press_in  = press_inc;
            since_repeat_in = repeat_inc;
            if ((held_key_ff != KEY_NONE) && (held_char_ff != CHAR_NONE) && delay_met &&
                (!repeated_once_ff || rate_met)) begin
               repeated_once_in = 1'b1;
               since_repeat_in  = '0;
               c                = held_char_ff;
               rep              = 1'b1;
            end
         end
      end
   end

   // Result fields show the modifier state after this item.
   always_comb begin
      result.char_valid  = (c != CHAR_NONE);
      result.char_code   = c;
      result.from_repeat = rep;
      result.shift_on    = shift_in.active;
      result.alt_on      = alt_in.active;
      result.sym_on      = sym_in.active;
   end

   // Translator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff         <= '0;
         alt_ff           <= '0;
         sym_ff           <= '0;
         held_key_ff      <= KEY_NONE;
         held_char_ff     <= CHAR_NONE;
         since_press_ff   <= '0;
         since_repeat_ff  <= '0;
         repeated_once_ff <= 1'b0;
      end else if (step_en) begin
         shift_ff         <= shift_in;
         alt_ff           <= alt_in;
         sym_ff           <= sym_in;
         held_key_ff      <= held_key_in;
         held_char_ff     <= held_char_in;
         since_press_ff   <= since_press_in;
         since_repeat_ff  <= since_repeat_in;
         repeated_once_ff <= repeated_once_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ketr_checker.sv
`default_nettype none

`include "keypad_event_translator_with_repeat_top_assert.svh"

module ketr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_char_valid,
   input wire logic [6:0] rsp_char_code,
   input wire logic       rsp_from_repeat
);

   // Back pressure on the input only comes from a stalled result.
   `KETR_ASSERT_NOW(a_stall_source, req_stall, rsp_valid && rsp_stall,
      "req_stall without a stalled result")

   // A result without a character carries no code and no repeat mark.
   `KETR_ASSERT_NOW(a_empty_result, rsp_valid && !rsp_char_valid,
      (rsp_char_code == 7'd0) && !rsp_from_repeat, "empty result carries data")

   // A repeat is always a real character.
   `KETR_ASSERT_NOW(a_repeat_char, rsp_valid && rsp_from_repeat,
      rsp_char_valid && (rsp_char_code != 7'd0), "repeat without a character")

   // A stalled result stays on the port unchanged.
   `KETR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_char_code) && $stable(rsp_char_valid), "stalled result changed")

endmodule

bind keypad_event_translator_with_repeat_top ketr_checker u_ketr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_char_code   (rsp_char_code),
   .rsp_from_repeat (rsp_from_repeat)
);

`default_nettype wire

>>> verif/keypad_event_translator_with_repeat_top_tb.sv
`timescale 1ns / 100ps

module keypad_event_translator_with_repeat_top_tb;
   import ketr_pkg::*;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;
   localparam int   IDLE_PCT  = 20;
   localparam int   HOLD_OFF  = 250;
   localparam int   PHASE_ITEMS = 64;

   typedef struct packed {
      logic       kind;
      logic [7:0] ev;
   } keypad_item_type;

   // Clock, reset and every block input start at known values.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_KEY;
   logic [7:0]            req_event_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_char_valid;
   logic [6:0]            rsp_char_code;
   logic                  rsp_from_repeat;
   logic                  rsp_shift_on;
   logic                  rsp_alt_on;
   logic                  rsp_sym_on;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Items waiting to be offered and characters waiting to come out.
   keypad_item_type pending_items[$];
   result_type expected_chars[$];
   int         items_queued = 0;
   int         items_taken = 0;
   int         error_count = 0;
   int         chars_seen = 0;
   int         repeats_seen = 0;
   int         hold_requests = 0;
   bit         calm = 1'b0;

   // Shadow of the translator: registers and key state.
   cfg_type     live_cfg = '{enable: 1'b0, delay: DELAY_RESET, rate: RATE_RESET};
   mod_type     shift_st = '0;
   mod_type     alt_st = '0;
   mod_type     sym_st = '0;
   logic [6:0]  held_key = KEY_NONE;
   logic [6:0]  held_char = CHAR_NONE;
   logic [15:0] since_press = '0;
   logic [15:0] since_repeat = '0;
   logic        repeated_once = 1'b0;

   keypad_event_translator_with_repeat_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_event_byte  (req_event_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_char_code   (rsp_char_code),
      .rsp_from_repeat (rsp_from_repeat),
      .rsp_shift_on    (rsp_shift_on),
      .rsp_alt_on      (rsp_alt_on),
      .rsp_sym_on      (rsp_sym_on),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   // Tick counters stop at their top value.
   function automatic logic [15:0] next_count(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // A key that uses a modifier drops it if tapped, or marks it if held.
   function automatic mod_type take_mod(input mod_type m);
      mod_type n;
      n = m;
      if (m.active && m.held) n.used = 1'b1;
      if (m.active && !m.held) n.active = 1'b0;
      return n;
   endfunction

   // Letting go of a modifier keeps a tap armed, but not one used while held.
   function automatic mod_type drop_mod(input mod_type m);
      mod_type n;
      n = '0;
      n.active = m.active && !m.used;
      return n;
   endfunction

   // Character printed on a key, in the plain or the symbol layer.
   function automatic logic [6:0] glyph(input logic [6:0] code, input bit symbols);
      string      top;
      string      mid;
      string      bot;
      logic [6:0] c;
      top = symbols ? "@+-_)(321#" : "poiuytrewq";
      mid = symbols ? "\"';:/654*" : "lkjhgfdsa";
      bot = symbols ? ".,!?987" : "mnbvcxz";
      c = CHAR_NONE;
      if (code >= 1 && code <= 10) begin
         c = 7'(top.getc(code - 1));
      end else if (code >= 12 && code <= 20) begin
         c = 7'(mid.getc(code - 12));
      end else if (code >= 23 && code <= 29) begin
         c = 7'(bot.getc(code - 23));
      end else if (!symbols && code == 11) begin
         c = 7'h08;
      end else if (!symbols && code == 21) begin
         c = 7'h0D;
      end else if (!symbols && code == 33) begin
         c = 7'h20;
      end
      return c;
   endfunction

   // Advance the shadow by one item and return the character it should cause.
   function automatic result_type translate_item(input logic kind, input logic [7:0] ev);
      result_type r;
      logic [6:0] code;
      logic [6:0] c;
      logic       rep;
      code = ev[6:0];
      c = CHAR_NONE;
      rep = 1'b0;
      if (live_cfg.enable && kind == KIND_KEY && !ev[PRESS_BIT]) begin
         // Key lifted: modifiers drop, and the held key stops repeating.
         if (code == KEY_SHIFT_L || code == KEY_SHIFT_R) shift_st = drop_mod(shift_st);
         if (code == KEY_ALT) alt_st = drop_mod(alt_st);
         if (code == KEY_SYM) sym_st = drop_mod(sym_st);
         if (code == held_key) held_key = KEY_NONE;
      end else if (live_cfg.enable && kind == KIND_KEY) begin
         if (code == KEY_SHIFT_L || code == KEY_SHIFT_R) begin
            shift_st = MOD_PRESSED;
         end else if (code == KEY_ALT) begin
            alt_st = MOD_PRESSED;
         end else if (code == KEY_SYM) begin
            sym_st = MOD_PRESSED;
         end else begin
            if (code == KEY_DOLLAR) begin
               c = CHAR_DOLLAR;
               sym_st.active = 1'b0;
            end else if (code == KEY_MIC) begin
               if (alt_st.active || sym_st.active) begin
                  c = CHAR_ZERO;
                  alt_st = take_mod(alt_st);
                  sym_st = take_mod(sym_st);
               end else begin
                  c = CHAR_MIC;
               end
            end else if (alt_st.active || sym_st.active) begin
               // Symbol layer, falling back to the plain character.
               c = glyph(code, 1'b1);
               if (c == CHAR_NONE) c = glyph(code, 1'b0);
               alt_st = take_mod(alt_st);
               sym_st = take_mod(sym_st);
            end else begin
               c = glyph(code, 1'b0);
               if (c != CHAR_NONE && shift_st.active) begin
                  if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) c = c - CASE_OFFSET;
                  shift_st = take_mod(shift_st);
               end
            end
            if (c != CHAR_NONE) begin
               held_key = code;
               held_char = c;
               since_press = '0;
               since_repeat = '0;
               repeated_once = 1'b0;
            end
         end
      end else if (live_cfg.enable) begin
         // Millisecond tick: typematic repeat after the delay, then at the rate.
         since_press = next_count(since_press);
         since_repeat = next_count(since_repeat);
         if (held_key != KEY_NONE && held_char != CHAR_NONE && since_press >= live_cfg.delay
             && (!repeated_once || since_repeat >= live_cfg.rate)) begin
            repeated_once = 1'b1;
            since_repeat = '0;
            c = held_char;
            rep = 1'b1;
         end
      end
      r.char_valid = (c != CHAR_NONE);
      r.char_code = c;
      r.from_repeat = rep;
      r.shift_on = shift_st.active;
      r.alt_on = alt_st.active;
      r.sym_on = sym_st.active;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Driver: offers queued items, holds a stalled one, idles at random.
   always @(posedge clock) begin : driver
      keypad_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_chars.push_back(translate_item(req_kind, req_event_byte));
            items_taken++;
         end
         if (req_valid && req_stall) begin
            // The stalled item stays on the bus unchanged.
         end else if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = pending_items.pop_front();
            req_valid <= 1'b1;
            req_kind <= nxt.kind;
            req_event_byte <= nxt.ev;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted result and drives the receiver stall.
   always @(posedge clock) begin : monitor
      result_type want;
      int         hold_served;
      int         hold_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_served = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("result arrived with no item outstanding");
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               check_field("char_valid", 32'(want.char_valid), 32'(rsp_char_valid));
               check_field("char_code", 32'(want.char_code), 32'(rsp_char_code));
               check_field("from_repeat", 32'(want.from_repeat), 32'(rsp_from_repeat));
               check_field("shift_on", 32'(want.shift_on), 32'(rsp_shift_on));
               check_field("alt_on", 32'(want.alt_on), 32'(rsp_alt_on));
               check_field("sym_on", 32'(want.sym_on), 32'(rsp_sym_on));
               if (rsp_char_valid) chars_seen++;
               if (rsp_from_repeat) repeats_seen++;
            end
         end
         // A requested hold-off stalls the output long enough to back up the input.
         if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_OFF;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic queue_item(input logic kind, input logic [7:0] ev);
      pending_items.push_back('{kind: kind, ev: ev});
      items_queued++;
   endtask

   task automatic press_key(input logic [6:0] code);
      queue_item(KIND_KEY, {1'b1, code});
   endtask

   task automatic lift_key(input logic [6:0] code);
      queue_item(KIND_KEY, {1'b0, code});
   endtask

   task automatic ticks(input int n);
      repeat (n) queue_item(KIND_TICK, 8'($urandom));
   endtask

   // One bus transfer: setup cycle, then access until pready.
   task automatic csr_cycle(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Write a register, mirror it in the shadow and read it back.
   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      logic [31:0] mask;
      csr_cycle(idx, 1'b1, value, rd);
      case (idx)
         REG_ENABLE: begin
            live_cfg.enable = value[0];
            mask = 32'h1;
         end
         REG_DELAY: begin
            live_cfg.delay = value[15:0];
            mask = 32'hFFFF;
         end
         default: begin
            live_cfg.rate = value[15:0];
            mask = 32'hFFFF;
         end
      endcase
      csr_cycle(idx, 1'b0, '0, rd);
      if ((rd & mask) !== (value & mask)) begin
         $error("register %0d: expected %0h, got %0h", idx, value & mask, rd & mask);
         error_count++;
      end
   endtask

   // Wait until every queued item has been taken and answered, then let the pipe empty.
   task automatic wait_drained();
      do @(posedge clock); while (items_taken != items_queued || expected_chars.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One random typing sequence: mostly well-formed, some noise.
   task automatic random_burst();
      int         pick;
      int         n;
      logic [6:0] key;
      logic [6:0] other;
      logic [6:0] modkey;
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 34));
      other = 7'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
         0: modkey = KEY_SHIFT_L;
         1: modkey = KEY_SHIFT_R;
         2: modkey = KEY_ALT;
         default: modkey = KEY_SYM;
      endcase
      if (pick < 40) begin
         press_key(key);
         ticks($urandom_range(0, 12));
         if ($urandom_range(0, 4) != 0) lift_key(key);
      end else if (pick < 60) begin
         press_key(modkey);
         lift_key(modkey);
         press_key(key);
         ticks($urandom_range(0, 6));
         lift_key(key);
      end else if (pick < 75) begin
         press_key(modkey);
         n = $urandom_range(1, 3);
         repeat (n) begin
            press_key(7'($urandom_range(1, 34)));
            ticks($urandom_range(0, 3));
            lift_key(7'($urandom_range(1, 34)));
         end
         lift_key(modkey);
      end else if (pick < 85) begin
         // Lifting some other key must not stop the repeat.
         press_key(key);
         ticks($urandom_range(0, 4));
         lift_key(other);
         ticks($urandom_range(0, 8));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) queue_item(1'($urandom), 8'($urandom));
      end
   endtask

   // Stimulus and register plan.
   initial begin : stimulus
      cfg_type plan [7];
      int      start;
      plan[0] = '{enable: 1'b1, delay: 16'd3, rate: 16'd2};
      plan[1] = '{enable: 1'b1, delay: 16'd0, rate: 16'd0};
      plan[2] = '{enable: 1'b1, delay: 16'd2, rate: 16'd1};
      plan[3] = '{enable: 1'b1, delay: 16'd1, rate: 16'hFFFF};
      plan[4] = '{enable: 1'b0, delay: 16'd5, rate: 16'd5};
      plan[5] = '{enable: 1'b1, delay: 16'hFFFF, rate: 16'd0};
      plan[6] = '{enable: 1'b1, delay: 16'd4, rate: 16'd3};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the block is disabled: no characters come out, state holds.
      press_key(KEY_SHIFT_L);
      press_key(7'd20);
      ticks(2);
      lift_key(7'd20);
      wait_drained();
      set_register(REG_ENABLE, 32'd1);

      // Directed: tapped and held modifiers, special keys, odd codes.
      press_key(KEY_SHIFT_L);
      lift_key(KEY_SHIFT_L);
      press_key(7'd20);
      lift_key(7'd20);
      press_key(KEY_SHIFT_R);
      press_key(7'd1);
      press_key(7'd29);
      lift_key(7'd29);
      lift_key(KEY_SHIFT_R);
      press_key(KEY_ALT);
      lift_key(KEY_ALT);
      press_key(7'd10);
      press_key(KEY_SYM);
      press_key(7'd11);
      lift_key(KEY_SYM);
      press_key(KEY_DOLLAR);
      press_key(KEY_MIC);
      press_key(KEY_ALT);
      press_key(KEY_MIC);
      lift_key(KEY_ALT);
      press_key(KEY_SYM);
      lift_key(KEY_SYM);
      queue_item(KIND_KEY, 8'hFF);
      queue_item(KIND_KEY, 8'h00);
      queue_item(KIND_KEY, 8'h80);
      press_key(7'd33);
      // Held key under the reset timing: first repeat after the default delay.
      press_key(7'd10);
      ticks(402);
      lift_key(7'd10);
      wait_drained();

      // Random phases, each under its own register setting.
      foreach (plan[i]) begin
         set_register(REG_ENABLE, 32'(plan[i].enable));
         set_register(REG_DELAY, 32'(plan[i].delay));
         set_register(REG_RATE, 32'(plan[i].rate));
         calm = (i == 3);
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) random_burst();
         if (i == 2) hold_requests++;
         wait_drained();
         calm = 1'b0;
      end

      $display("Checked %0d items over %0d register settings: %0d characters, %0d repeats.",
               items_taken, $size(plan) + 1, chars_seen, repeats_seen);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ketr_pkg.sv
rtl/ketr_step.sv
rtl/keypad_event_translator_with_repeat_top.sv
rtl/ketr_checker.sv
verif/keypad_event_translator_with_repeat_top_tb.sv
